// File: rtl/core/prr_pkg.sv
`default_nettype none

package prr_pkg;

  localparam int NUM_SETS_DEF     = 2048;
  localparam int NUM_WAYS_DEF     = 16;
  localparam int WINDOW_LEN_DEF   = 32;
  localparam int RECENT_DEPTH_DEF = 4;

  localparam int SET_IN_W  = 11;
  localparam int WAY_IN_W  = 4;
  localparam int LINE_W    = 58;
  localparam int VALID_W   = 16;
  localparam int THR_W     = 6;
  localparam int SUM_W     = 4;

  localparam logic [THR_W-1:0] THR_RESET     = 6'd26;
  localparam logic [2:0]       REUSE_LIMIT   = 3'd7;
  localparam logic [1:0]       RRIP_TOP      = 2'd3;
  localparam int               SPATIAL_LIMIT = 7;
  localparam logic [SUM_W-1:0] SUM_START     = 4'd15;

  // ways compared per scan cycle
  localparam int SCAN_CHUNK = 8;

  typedef enum logic {
    OP_VICTIM = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef struct packed {
    logic [2:0] spatial;
    logic [2:0] reuse;
    logic [1:0] rrip;
  } meta_t;

  localparam int META_W = $bits(meta_t);
  localparam meta_t META_RESET = '{spatial: 3'd0, reuse: 3'd0, rrip: RRIP_TOP};

  typedef struct packed {
    op_t                 op;
    logic [SET_IN_W-1:0] set_index;
    logic [WAY_IN_W-1:0] way;
    logic [LINE_W-1:0]   line_addr;
    logic                hit;
    logic [VALID_W-1:0]  way_valid;
  } item_t;

  typedef struct packed {
    logic [WAY_IN_W-1:0] victim_way;
    logic                streaming;
  } result_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/prr_row_update.sv
`default_nettype none

module prr_row_update #(
  parameter int NUM_WAYS     = prr_pkg::NUM_WAYS_DEF,
  parameter int WINDOW_LEN   = prr_pkg::WINDOW_LEN_DEF,
  parameter int RECENT_DEPTH = prr_pkg::RECENT_DEPTH_DEF
) (
  input  prr_pkg::item_t                                             item,
  input  logic [prr_pkg::THR_W-1:0]                                  threshold,
  input  prr_pkg::meta_t [NUM_WAYS-1:0]                              meta_in,
  input  logic [prr_pkg::idx_w(WINDOW_LEN)-1:0]                      wpos_in,
  input  logic [prr_pkg::idx_w(WINDOW_LEN+1)-1:0]                    miss_in,
  input  logic                                                       strm_in,
  input  logic [prr_pkg::idx_w(RECENT_DEPTH)-1:0]                    rpos_in,
  input  logic [RECENT_DEPTH-1:0][prr_pkg::LINE_W-1:0]               recent_in,
  output prr_pkg::meta_t [NUM_WAYS-1:0]                              meta_out,
  output logic [prr_pkg::idx_w(WINDOW_LEN)-1:0]                      wpos_out,
  output logic [prr_pkg::idx_w(WINDOW_LEN+1)-1:0]                    miss_out,
  output logic                                                       strm_out,
  output logic [prr_pkg::idx_w(RECENT_DEPTH)-1:0]                    rpos_out,
  output logic [RECENT_DEPTH-1:0][prr_pkg::LINE_W-1:0]               recent_out
);
  import prr_pkg::*;

  localparam int WPOS_W = idx_w(WINDOW_LEN);
  localparam int MISS_W = idx_w(WINDOW_LEN + 1);
  localparam int RPOS_W = idx_w(RECENT_DEPTH);
  localparam int SC_W   = idx_w(RECENT_DEPTH + 1);
  localparam int CMP_W  = (MISS_W > THR_W) ? MISS_W : THR_W;

  logic [MISS_W-1:0] miss_inc;
  logic              win_end;
  logic [SC_W-1:0]   score;
  logic [2:0]        score_sat;
  logic [LINE_W:0]   diff [RECENT_DEPTH];

  // window of accesses
  always_comb begin
    miss_inc = item.hit ? miss_in : miss_in + 1'b1;
    win_end  = (wpos_in == WPOS_W'(WINDOW_LEN - 1));
    if (win_end) begin
      wpos_out = '0;
      miss_out = '0;
      strm_out = (CMP_W'(miss_inc) >= CMP_W'(threshold));
    end else begin
      wpos_out = wpos_in + 1'b1;
      miss_out = miss_inc;
      strm_out = strm_in;
    end
  end

  // spatial score against recent lines
  always_comb begin
    score = '0;
    for (int i = 0; i < RECENT_DEPTH; i++) begin
      diff[i] = {1'b0, recent_in[i]} - {1'b0, item.line_addr};
      if (recent_in[i] != '0 &&
          (diff[i] == (LINE_W+1)'(1) || diff[i] == (LINE_W+1)'(2) ||
           diff[i] == {(LINE_W+1){1'b1}} || diff[i] == {{LINE_W{1'b1}}, 1'b0})) begin
        score = score + 1'b1;
      end
    end
    score_sat = (32'(score) > SPATIAL_LIMIT) ? 3'(SPATIAL_LIMIT) : 3'(score);
  end

  always_comb begin
    recent_out = recent_in;
    for (int i = 0; i < RECENT_DEPTH; i++) begin
      if (RPOS_W'(i) == rpos_in) begin
        recent_out[i] = item.line_addr;
      end
    end
    rpos_out = (rpos_in == RPOS_W'(RECENT_DEPTH - 1)) ? '0 : rpos_in + 1'b1;
  end

  always_comb begin
    meta_out = meta_in;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (int'(item.way) == w) begin
        if (item.hit) begin
          meta_out[w].reuse   = (meta_in[w].reuse < REUSE_LIMIT) ?
                                meta_in[w].reuse + 3'd1 : REUSE_LIMIT;
          meta_out[w].rrip    = 2'd0;
          meta_out[w].spatial = (score_sat >= 3'd2) ? 3'd3 : score_sat + 3'd1;
        end else begin
          meta_out[w].reuse   = 3'd1;
          meta_out[w].spatial = score_sat;
          meta_out[w].rrip    = strm_out ? RRIP_TOP : 2'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/phase_adaptive_rrip_replacement_top.sv
`default_nettype none

// Replacement policy for a set-associative cache, one item per command.
// Input channel: an item on item is taken at a clock edge with start high
// and busy low. Op victim returns the first invalid way, or else the result
// of an in-order scan of the set's way metadata. Op update records the
// access in the set's miss window, scores spatial locality against the
// set's recent lines and rewrites the way's rrip, reuse and spatial fields.
// Result channel: result is shown for exactly one cycle with result_valid
// high; the receiver cannot stall it. streaming is the set's flag after the
// item.
// Storage: all per-set state sits in one row of a single
// synchronous memory. An update reads the row at acceptance, writes it back
// in the next cycle with the result, and start may be taken again the cycle
// after; busy is high until then. A victim request scans 8 ways per cycle after
// the read, with busy high until its result is shown.
// Reset: the memory is swept one row per cycle, all NUM_SETS rows (2048 by
// default), with busy high; the threshold resets to 26. Configuration
// (cfg_valid/cfg_ready/cfg_data) is taken at any time, cfg_ready is held high.
module phase_adaptive_rrip_replacement_top #(
  parameter int NUM_SETS     = prr_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS     = prr_pkg::NUM_WAYS_DEF,
  parameter int WINDOW_LEN   = prr_pkg::WINDOW_LEN_DEF,
  parameter int RECENT_DEPTH = prr_pkg::RECENT_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  prr_pkg::item_t            item,
  output logic                      result_valid,
  output prr_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [prr_pkg::THR_W-1:0] cfg_data
);
  import prr_pkg::*;

  localparam int SET_W      = idx_w(NUM_SETS);
  localparam int WAY_W      = idx_w(NUM_WAYS);
  localparam int WPOS_W     = idx_w(WINDOW_LEN);
  localparam int MISS_W     = idx_w(WINDOW_LEN + 1);
  localparam int RPOS_W     = idx_w(RECENT_DEPTH);
  localparam int WRAP_W     = SET_W + 4;
  localparam int NUM_CHUNKS = (NUM_WAYS + SCAN_CHUNK - 1) / SCAN_CHUNK;
  localparam int CH_W       = idx_w(NUM_CHUNKS);
  localparam int META_ROW_W = NUM_WAYS * META_W;
  localparam int REST_W     = WPOS_W + MISS_W + 1 + RPOS_W + RECENT_DEPTH * LINE_W;
  localparam int ROW_W      = META_ROW_W + REST_W;
  localparam logic [ROW_W-1:0] RESET_ROW = {{NUM_WAYS{META_RESET}}, REST_W'(0)};

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [THR_W-1:0]  threshold;
  logic [SET_W-1:0]  clr_cnt;
  logic [CH_W-1:0]   scan_cnt;
  item_t             item_q;
  logic [SET_W-1:0]  set_q;
  logic [WAY_W-1:0]  best_way;
  logic [1:0]        best_r;
  logic [SUM_W-1:0]  best_s;

  logic [ROW_W-1:0]  mem [NUM_SETS];
  logic [ROW_W-1:0]  rd_row;
  logic [ROW_W-1:0]  wr_row;
  logic              mem_we;
  logic [SET_W-1:0]  mem_waddr;
  logic [SET_W-1:0]  set_wrap;
  logic [WRAP_W-1:0] wrap_sum;

  meta_t [NUM_WAYS-1:0]             meta_q, meta_n;
  logic [WPOS_W-1:0]                wpos_q, wpos_n;
  logic [MISS_W-1:0]                miss_q, miss_n;
  logic                             strm_q, strm_n;
  logic [RPOS_W-1:0]                rpos_q, rpos_n;
  logic [RECENT_DEPTH-1:0][LINE_W-1:0] recent_q, recent_n;

  logic              accept;
  logic              scan_last;
  logic [WAY_W-1:0]  sc_w;
  logic [1:0]        sc_r;
  logic [SUM_W-1:0]  sc_s;
  logic [NUM_WAYS-1:0] valid_ext;
  logic              inv_any;
  logic [WAY_W-1:0]  inv_way;

  function automatic logic [WRAP_W-1:0] pow2_mod(input int i);
    logic [WRAP_W:0] r;
    r = (NUM_SETS == 1) ? '0 : (WRAP_W+1)'(1);
    for (int k = 0; k < i; k++) begin
      r = r << 1;
      if (r >= (WRAP_W+1)'(NUM_SETS)) begin
        r = r - (WRAP_W+1)'(NUM_SETS);
      end
    end
    return WRAP_W'(r);
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_last = (scan_cnt == CH_W'(NUM_CHUNKS - 1));

  // set index wrap: sum of per-bit residues, then binary reduction
  always_comb begin
    wrap_sum = '0;
    for (int i = 0; i < SET_IN_W; i++) begin
      if (item.set_index[i]) begin
        wrap_sum = wrap_sum + pow2_mod(i);
      end
    end
    for (int k = 3; k >= 0; k--) begin
      if (wrap_sum >= WRAP_W'(NUM_SETS << k)) begin
        wrap_sum = wrap_sum - WRAP_W'(NUM_SETS << k);
      end
    end
    set_wrap = SET_W'(wrap_sum);
  end

  assign {meta_q, wpos_q, miss_q, strm_q, rpos_q, recent_q} = rd_row;

  prr_row_update #(
    .NUM_WAYS     (NUM_WAYS),
    .WINDOW_LEN   (WINDOW_LEN),
    .RECENT_DEPTH (RECENT_DEPTH)
  ) u_update (
    .item       (item_q),
    .threshold  (threshold),
    .meta_in    (meta_q),
    .wpos_in    (wpos_q),
    .miss_in    (miss_q),
    .strm_in    (strm_q),
    .rpos_in    (rpos_q),
    .recent_in  (recent_q),
    .meta_out   (meta_n),
    .wpos_out   (wpos_n),
    .miss_out   (miss_n),
    .strm_out   (strm_n),
    .rpos_out   (rpos_n),
    .recent_out (recent_n)
  );

  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_UPDATE);
    mem_waddr = (state == S_CLEAR) ? clr_cnt : set_q;
    wr_row    = (state == S_CLEAR) ? RESET_ROW :
                {meta_n, wpos_n, miss_n, strm_n, rpos_n, recent_n};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wr_row;
    end
    if (accept) begin
      rd_row <= mem[set_wrap];
    end
  end

  // in-order scan, a way replaces the best when it dominates it
  always_comb begin
    int w;
    meta_t m;
    logic [SUM_W-1:0] s;
    m = '0;
    s = '0;
    sc_w = (scan_cnt == '0) ? '0        : best_way;
    sc_r = (scan_cnt == '0) ? 2'd0      : best_r;
    sc_s = (scan_cnt == '0) ? SUM_START : best_s;
    for (int j = 0; j < SCAN_CHUNK; j++) begin
      w = int'(scan_cnt) * SCAN_CHUNK + j;
      if (w < NUM_WAYS) begin
        m = meta_q[WAY_W'(w)];
        s = SUM_W'(m.reuse) + SUM_W'(m.spatial);
        if (m.rrip >= sc_r && s <= sc_s && (m.rrip != sc_r || s != sc_s)) begin
          sc_w = WAY_W'(w);
          sc_r = m.rrip;
          sc_s = s;
        end
      end
    end
  end

  // first invalid way, ways above the valid field count as invalid
  always_comb begin
    valid_ext = NUM_WAYS'(item_q.way_valid);
    inv_any   = 1'b0;
    inv_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (!valid_ext[w]) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == SET_W'(NUM_SETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = (item.op == OP_UPDATE) ? S_UPDATE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_IDLE;
        end
      end
      S_UPDATE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      scan_cnt     <= '0;
      threshold    <= THR_RESET;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept) begin
        scan_cnt <= '0;
      end else if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
        if (scan_last) begin
          result_valid <= 1'b1;
        end
      end
      if (state == S_UPDATE) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
      set_q  <= set_wrap;
    end
    if (state == S_SCAN) begin
      best_way <= sc_w;
      best_r   <= sc_r;
      best_s   <= sc_s;
      if (scan_last) begin
        result.victim_way <= WAY_IN_W'(inv_any ? inv_way : sc_w);
        result.streaming  <= strm_q;
      end
    end
    if (state == S_UPDATE) begin
      result.victim_way <= '0;
      result.streaming  <= strm_n;
    end
  end

endmodule

`default_nettype wire

// File: test/rrip_policy_checker.sv
`timescale 1ns / 1ps

module rrip_policy_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  prr_pkg::item_t            item,
  input  logic                      result_valid,
  input  prr_pkg::result_t          result,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [prr_pkg::THR_W-1:0] cfg_data,
  output int                        outstanding,
  output int                        mismatches
);
  import prr_pkg::*;

  localparam int SETS      = 2048;
  localparam int WAYS      = 16;
  localparam int DEPTH     = 4;
  localparam int WIN       = 32;
  localparam int REPORT_MAX = 100;
  localparam logic [3:0]        SUM_INIT = 4'd15;
  localparam logic [LINE_W-1:0] NEAR     = 2;

  meta_t             meta_tbl   [SETS][WAYS];
  logic [5:0]        win_pos    [SETS];
  logic [5:0]        win_miss   [SETS];
  logic              stream_flag[SETS];
  logic [LINE_W-1:0] recent_tbl [SETS][DEPTH];
  logic [1:0]        recent_wr  [SETS];
  logic [THR_W-1:0]  miss_thr;
  result_t           outcome_q  [$];
  result_t           want;
  int                fail_count;
  int                si;
  int                wi;

  function automatic logic [3:0] rrip_victim(input logic [SET_IN_W-1:0] s,
                                             input logic [VALID_W-1:0] valid);
    int w;
    int r;
    int sum;
    int best_r;
    int best_sum;
    logic [3:0] pick;
    pick = '0;
    best_r = 0;
    best_sum = SUM_INIT;
    for (w = 0; w < WAYS; w++) begin
      if (!valid[w]) return 4'(w);
    end
    for (w = 0; w < WAYS; w++) begin
      r = meta_tbl[s][w].rrip;
      sum = meta_tbl[s][w].reuse + meta_tbl[s][w].spatial;
      if (!stream_flag[s]) begin
        if (r >= best_r && (sum < best_sum || (sum == best_sum && r > best_r))) begin
          pick = 4'(w);
          best_r = r;
          best_sum = sum;
        end
      end else begin
        if (sum <= best_sum && (r > best_r || (r == best_r && sum < best_sum))) begin
          pick = 4'(w);
          best_r = r;
          best_sum = sum;
        end
      end
    end
    return pick;
  endfunction

  function automatic void rrip_access(input item_t it);
    logic [SET_IN_W-1:0] s;
    logic [LINE_W-1:0]   a;
    logic [LINE_W-1:0]   gap;
    meta_t               m;
    int                  score;
    int                  i;
    s = it.set_index;
    if (!it.hit) win_miss[s] = win_miss[s] + 6'd1;
    win_pos[s] = win_pos[s] + 6'd1;
    if (win_pos[s] >= WIN) begin
      stream_flag[s] = (win_miss[s] >= miss_thr);
      win_pos[s] = '0;
      win_miss[s] = '0;
    end
    // spatial score uses the recent lines before this one is recorded
    score = 0;
    for (i = 0; i < DEPTH; i++) begin
      a = recent_tbl[s][i];
      if (a != '0 && a != it.line_addr) begin
        gap = (a > it.line_addr) ? a - it.line_addr : it.line_addr - a;
        if (gap <= NEAR) score++;
      end
    end
    if (score > 7) score = 7;
    recent_tbl[s][recent_wr[s]] = it.line_addr;
    recent_wr[s] = recent_wr[s] + 2'd1;
    m = meta_tbl[s][it.way];
    if (it.hit) begin
      if (m.reuse != 3'd7) m.reuse = m.reuse + 3'd1;
      m.rrip = 2'd0;
      m.spatial = (score + 1 < 3) ? 3'(score + 1) : 3'd3;
    end else begin
      m.reuse = 3'd1;
      m.spatial = 3'(score);
      m.rrip = stream_flag[s] ? 2'd3 : 2'd0;
    end
    meta_tbl[s][it.way] = m;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (si = 0; si < SETS; si++) begin
        for (wi = 0; wi < WAYS; wi++) begin
          meta_tbl[si][wi] = '{spatial: 3'd0, reuse: 3'd0, rrip: 2'd3};
        end
        for (wi = 0; wi < DEPTH; wi++) begin
          recent_tbl[si][wi] = '0;
        end
        win_pos[si] = '0;
        win_miss[si] = '0;
        stream_flag[si] = 1'b0;
        recent_wr[si] = '0;
      end
      miss_thr = 6'd26;
      outcome_q.delete();
      fail_count = 0;
    end else begin
      if (result_valid) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $error("unexpected result: victim_way %0d streaming %0b",
                   result.victim_way, result.streaming);
        end else begin
          want = outcome_q.pop_front();
          if (result.victim_way !== want.victim_way) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $error("victim_way expected %0d actual %0d",
                     want.victim_way, result.victim_way);
          end
          if (result.streaming !== want.streaming) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $error("streaming expected %0b actual %0b",
                     want.streaming, result.streaming);
          end
        end
      end
      if (cfg_valid && cfg_ready) miss_thr = cfg_data;
      if (start && !busy) begin
        want = '0;
        if (item.op == OP_VICTIM)
          want.victim_way = rrip_victim(item.set_index, item.way_valid);
        else
          rrip_access(item);
        want.streaming = stream_flag[item.set_index];
        outcome_q.push_back(want);
      end
    end
    outstanding <= outcome_q.size();
    mismatches <= fail_count;
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import prr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 125;
  localparam int HOT         = 3;
  localparam logic [LINE_W-1:0] LMAX = '1;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  item_t            item = '0;
  logic             result_valid;
  result_t          result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;
  int               outstanding;
  int               mismatches;
  int               cycles = 0;
  bit               idle_en = 1'b1;
  int               miss_pct = 50;
  int               p;
  logic [SET_IN_W-1:0] hot_sets [HOT];
  logic [LINE_W-1:0]   hot_base [HOT];
  logic [THR_W-1:0]    thr_plan [PHASES];
  int                  miss_plan[PHASES];

  always #1 clk = ~clk;

  phase_adaptive_rrip_replacement_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  rrip_policy_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic item_t pack_item(input op_t op, input int s, input int w,
                                      input logic [LINE_W-1:0] line, input bit hit,
                                      input logic [VALID_W-1:0] valid);
    item_t it;
    it.op = op;
    it.set_index = SET_IN_W'(s);
    it.way = WAY_IN_W'(w);
    it.line_addr = line;
    it.hit = hit;
    it.way_valid = valid;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int k;
    k = $urandom_range(0, HOT - 1);
    it.op = ($urandom_range(0, 99) < 70) ? OP_UPDATE : OP_VICTIM;
    it.set_index = ($urandom_range(0, 9) == 0) ? SET_IN_W'($urandom) : hot_sets[k];
    it.way = WAY_IN_W'($urandom_range(0, 15));
    case ($urandom_range(0, 19))
      0: it.line_addr = '0;
      1, 2: it.line_addr = LINE_W'({$urandom, $urandom});
      default: it.line_addr = hot_base[k] + LINE_W'($urandom_range(0, 6));
    endcase
    it.hit = ($urandom_range(0, 99) >= miss_pct);
    case ($urandom_range(0, 6))
      0: it.way_valid = VALID_W'($urandom);
      1: begin
        it.way_valid = '1;
        it.way_valid[$urandom_range(0, 15)] = 1'b0;
      end
      default: it.way_valid = '1;
    endcase
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while (idle_en && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_thr(input logic [THR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    hot_sets[2] = SET_IN_W'($urandom_range(1, 2046));
    hot_base[0] = LMAX - 3;
    hot_base[1] = 1;
    hot_base[2] = LINE_W'({$urandom, $urandom});
    thr_plan = '{6'd0, 6'd32, 6'd63, 6'd1, 6'd26, 6'd0};
    thr_plan[5] = THR_W'($urandom_range(2, 31));
    miss_plan = '{85, 100, 90, 60, 90, 50};
    miss_plan[5] = $urandom_range(10, 100);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // first invalid way, full sets at reset metadata, extreme sets and lines
    send_item(pack_item(OP_VICTIM, 0, 0, '0, 1'b0, 16'h0000));
    send_item(pack_item(OP_VICTIM, 2047, 15, LMAX, 1'b1, 16'hFFFF));
    send_item(pack_item(OP_VICTIM, 5, 0, '0, 1'b0, 16'h7FFF));
    send_item(pack_item(OP_UPDATE, 0, 0, LMAX, 1'b1, 16'h0000));
    send_item(pack_item(OP_UPDATE, 0, 15, LMAX - 1, 1'b0, 16'hFFFF));
    send_item(pack_item(OP_UPDATE, 0, 3, LMAX - 2, 1'b1, 16'h0000));
    send_item(pack_item(OP_UPDATE, 0, 4, '0, 1'b0, 16'h0000));
    send_item(pack_item(OP_UPDATE, 0, 5, 2, 1'b1, 16'h0000));
    send_item(pack_item(OP_UPDATE, 0, 6, LMAX, 1'b0, 16'h0000));
    send_item(pack_item(OP_VICTIM, 0, 0, '0, 1'b0, 16'hFFFF));
    send_item(pack_item(OP_VICTIM, 0, 0, '0, 1'b0, 16'hFFEF));
    send_item(pack_item(OP_UPDATE, 2047, 15, 1, 1'b1, 16'h0000));
    send_item(pack_item(OP_VICTIM, 2047, 0, '0, 1'b0, 16'hFFFF));
    send_item(pack_item(OP_UPDATE, 2047, 15, 3, 1'b0, 16'h0000));
    // reuse saturation on repeated hits
    repeat (8) send_item(pack_item(OP_UPDATE, 2047, 15, 4, 1'b1, 16'h0000));
    send_item(pack_item(OP_VICTIM, 2047, 0, '0, 1'b0, 16'hFFFF));
    drain();

    for (p = 0; p < PHASES; p++) begin
      write_thr(thr_plan[p]);
      idle_en = (p != 3);
      miss_pct = miss_plan[p];
      repeat (PHASE_ITEMS) send_item(random_item());
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/prr_pkg.sv
rtl/core/prr_row_update.sv
rtl/core/phase_adaptive_rrip_replacement_top.sv
test/rrip_policy_checker.sv
test/tb.sv
